// ===== sv/bpt_pkg.sv =====
`default_nettype none
package bpt_pkg;

  localparam int TABLE_DEPTH  = 256;
  localparam int ADDRESS_BITS = 48;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);
  localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W      = ADDRESS_BITS + 8;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RANGE    = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_BADIDX   = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;

  typedef struct packed {
    logic [47:0] text_base;
    logic [31:0] text_length;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        hit;
    logic [7:0]  index;
    logic [47:0] address;
    logic [7:0]  sbyte;
    logic [8:0]  count;
  } res_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } mem_req_t;

endpackage
`default_nettype wire

// ===== sv/bpt_ram.sv =====
`default_nettype none
module bpt_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 56
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/bpt_ctrl.sv =====
`default_nettype none
module bpt_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_mode,
  input  wire logic [47:0]                 in_addr,
  input  wire logic [7:0]                  in_byte,
  input  wire logic [7:0]                  in_idx,
  input  wire bpt_pkg::cfg_t               cfg,
  output bpt_pkg::mem_req_t                mem_req,
  input  wire logic [bpt_pkg::ENTRY_W-1:0] rd_data,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output bpt_pkg::res_t                    res
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                              state_r, state_nxt;
  logic [bpt_pkg::CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [bpt_pkg::CNT_W-1:0]           ptr_r, ptr_nxt;
  logic                                chk_vld_r, chk_vld_nxt;
  logic [bpt_pkg::IDX_W-1:0]           chk_idx_r, chk_idx_nxt;
  logic [bpt_pkg::IDX_W-1:0]           idx_r, idx_nxt;
  logic [1:0]                          mode_r, mode_nxt;
  logic [bpt_pkg::ADDRESS_BITS-1:0]    addr_r, addr_nxt;
  logic [7:0]                          byte_r, byte_nxt;
  bpt_pkg::res_t                       res_r, res_nxt;

  logic [bpt_pkg::ADDRESS_BITS-1:0]    in_addr_m;
  logic [47:0]                         in_addr48;
  logic                                in_window;
  logic [bpt_pkg::ADDRESS_BITS-1:0]    rd_addr;
  logic [7:0]                          rd_byte;
  logic                                scan_end;

  assign in_addr_m = bpt_pkg::ADDRESS_BITS'(in_addr);
  assign in_addr48 = 48'(in_addr_m);
  assign in_window = (in_addr48 >= cfg.text_base) &&
                     ((in_addr48 - cfg.text_base) < 48'(cfg.text_length));
  assign rd_addr   = rd_data[bpt_pkg::ENTRY_W-1:8];
  assign rd_byte   = rd_data[7:0];
  assign scan_end  = !chk_vld_r && (ptr_r == cnt_r);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    ptr_nxt     = ptr_r;
    chk_vld_nxt = 1'b0;
    chk_idx_nxt = chk_idx_r;
    idx_nxt     = idx_r;
    mode_nxt    = mode_r;
    addr_nxt    = addr_r;
    byte_nxt    = byte_r;
    res_nxt     = res_r;
    mem_req     = '0;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_nxt = in_mode;
          addr_nxt = in_addr_m;
          byte_nxt = in_byte;
          res_nxt  = '0;
          case (in_mode)
            bpt_pkg::MODE_INSERT: begin
              if (!in_window) begin
                res_nxt.status = bpt_pkg::ST_RANGE;
                state_nxt      = S_DONE;
              end else begin
                ptr_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            bpt_pkg::MODE_LOOKUP: begin
              ptr_nxt   = '0;
              state_nxt = S_SCAN;
            end
            bpt_pkg::MODE_DELETE: begin
              if (32'(in_idx) >= 32'(cnt_r)) begin
                res_nxt.status = bpt_pkg::ST_BADIDX;
                state_nxt      = S_DONE;
              end else begin
                idx_nxt       = bpt_pkg::IDX_W'(in_idx);
                mem_req.re    = 1'b1;
                mem_req.raddr = bpt_pkg::IDX_W'(in_idx);
                chk_vld_nxt   = 1'b1;
                chk_idx_nxt   = bpt_pkg::IDX_W'(in_idx);
                ptr_nxt       = bpt_pkg::CNT_W'(in_idx) + bpt_pkg::CNT_W'(1);
                state_nxt     = S_SHIFT;
              end
            end
            default: begin
              res_nxt.status = bpt_pkg::ST_OK;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (chk_vld_r && (rd_addr == addr_r)) begin
          res_nxt.index   = 8'(chk_idx_r);
          res_nxt.address = 48'(rd_addr);
          res_nxt.sbyte   = rd_byte;
          if (mode_r == bpt_pkg::MODE_INSERT) begin
            res_nxt.status = bpt_pkg::ST_DUP;
          end else begin
            res_nxt.status = bpt_pkg::ST_OK;
            res_nxt.hit    = 1'b1;
          end
          state_nxt = S_DONE;
        end else if (scan_end) begin
          if (mode_r == bpt_pkg::MODE_INSERT) begin
            if (cnt_r == bpt_pkg::CNT_W'(bpt_pkg::TABLE_DEPTH)) begin
              res_nxt.status = bpt_pkg::ST_FULL;
            end else begin
              mem_req.we      = 1'b1;
              mem_req.waddr   = bpt_pkg::IDX_W'(cnt_r);
              mem_req.wdata   = {addr_r, byte_r};
              cnt_nxt         = cnt_r + bpt_pkg::CNT_W'(1);
              res_nxt.status  = bpt_pkg::ST_OK;
              res_nxt.index   = 8'(cnt_r);
              res_nxt.address = 48'(addr_r);
              res_nxt.sbyte   = byte_r;
            end
          end else begin
            res_nxt.status = bpt_pkg::ST_NOTFOUND;
          end
          state_nxt = S_DONE;
        end else if (ptr_r < cnt_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = bpt_pkg::IDX_W'(ptr_r);
          chk_vld_nxt   = 1'b1;
          chk_idx_nxt   = bpt_pkg::IDX_W'(ptr_r);
          ptr_nxt       = ptr_r + bpt_pkg::CNT_W'(1);
        end
      end
      S_SHIFT: begin
        // read runs one entry ahead of the write-back, never the same entry
        if (chk_vld_r) begin
          if (chk_idx_r == idx_r) begin
            res_nxt.address = 48'(rd_addr);
            res_nxt.sbyte   = rd_byte;
          end else begin
            mem_req.we    = 1'b1;
            mem_req.waddr = chk_idx_r - bpt_pkg::IDX_W'(1);
            mem_req.wdata = rd_data;
          end
        end
        if (scan_end) begin
          cnt_nxt        = cnt_r - bpt_pkg::CNT_W'(1);
          res_nxt.status = bpt_pkg::ST_OK;
          res_nxt.index  = 8'(idx_r);
          state_nxt      = S_DONE;
        end else if (ptr_r < cnt_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = bpt_pkg::IDX_W'(ptr_r);
          chk_vld_nxt   = 1'b1;
          chk_idx_nxt   = bpt_pkg::IDX_W'(ptr_r);
          ptr_nxt       = ptr_r + bpt_pkg::CNT_W'(1);
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res       = res_r;
    res.count = 9'(cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      chk_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      chk_vld_r <= chk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    chk_idx_r <= chk_idx_nxt;
    idx_r     <= idx_nxt;
    mode_r    <= mode_nxt;
    addr_r    <= addr_nxt;
    byte_r    <= byte_nxt;
    res_r     <= res_nxt;
  end

endmodule
`default_nettype wire

// ===== sv/breakpoint_table.sv =====
// Channel  Direction  Handshake              Payload
// in_      slave      in_tvalid/in_tready    tdata 64b, tuser 2b (mode)
// out_     master     out_tvalid/out_tready  tdata 80b, tuser 4b (status, hit)
// cfg_     APB slave  psel/penable, pready   pwdata/prdata 64b, paddr 4b
//
// One item at a time. Insert and lookup scan the table one entry a cycle
// through the memory read port. Delete reads and writes back every later
// entry. Range, bad-index and unused-mode beats go straight to the result
// without a memory access.
// A new beat is taken while the previous result waits in the output register.
// Synchronous reset empties the table; entry contents stay undefined.
`default_nettype none
module breakpoint_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // address[47:0], saved_byte, entry_index
  input  wire logic [1:0]  in_tuser,   // mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // found_index, found_address[47:0],
                                       // found_byte, entry_count[8:0], zero pad
  output logic [3:0]       out_tuser,  // status[2:0], hit
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [47:0]                  text_base_r;
  logic [31:0]                  text_length_r;
  bpt_pkg::cfg_t                cfg;
  bpt_pkg::mem_req_t            mem_req;
  logic [bpt_pkg::ENTRY_W-1:0]  rd_data;
  logic                         res_valid;
  logic                         res_ready;
  bpt_pkg::res_t                res;
  logic                         out_vld_r;
  bpt_pkg::res_t                out_res_r;
  logic                         cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_paddr[3] ? 64'(text_length_r) : 64'(text_base_r);
  assign cfg        = '{text_base: text_base_r, text_length: text_length_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_base_r   <= '0;
      text_length_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr[3]) begin
        text_length_r <= cfg_pwdata[31:0];
      end else begin
        text_base_r <= cfg_pwdata[47:0];
      end
    end
  end

  bpt_ram #(
    .DEPTH (bpt_pkg::TABLE_DEPTH),
    .WIDTH (bpt_pkg::ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rd_data)
  );

  bpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_mode   (in_tuser),
    .in_addr   (in_tdata[47:0]),
    .in_byte   (in_tdata[55:48]),
    .in_idx    (in_tdata[63:56]),
    .cfg       (cfg),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_res_r.count, out_res_r.sbyte, out_res_r.address,
                       out_res_r.index};
  assign out_tuser  = {out_res_r.hit, out_res_r.status};

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again while an operation is in flight");

  a_hit_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |-> out_tuser[2:0] == bpt_pkg::ST_OK)
    else $error("hit flagged on a failed operation");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(out_tdata[72:64]) <= bpt_pkg::TABLE_DEPTH)
    else $error("entry count beyond table depth");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[2:0] == bpt_pkg::ST_RANGE ||
                   out_tuser[2:0] == bpt_pkg::ST_FULL ||
                   out_tuser[2:0] == bpt_pkg::ST_BADIDX ||
                   out_tuser[2:0] == bpt_pkg::ST_NOTFOUND)
      |-> out_tdata[63:0] == 64'd0)
    else $error("failed operation carries entry data");

endmodule
`default_nettype wire

// ===== verif/breakpoint_table_test.sv =====
`default_nettype none
module breakpoint_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED     = 2'd3;
  localparam logic [3:0] REG_TEXT_BASE   = 4'd0;
  localparam logic [3:0] REG_TEXT_LENGTH = 4'd8;
  localparam int         QUIET_LIMIT     = 5000;
  localparam int         END_CYCLES      = 300;

  // Mirror of the breakpoint table and the results it is due to return
  class bp_table_mirror;
    logic [47:0]   bp_addr[bpt_pkg::TABLE_DEPTH];
    logic [7:0]    bp_byte[bpt_pkg::TABLE_DEPTH];
    int unsigned   n_valid;
    logic [47:0]   win_base;
    logic [31:0]   win_len;
    bpt_pkg::res_t pending_results[$];
    int unsigned   errors;

    function new();
      n_valid  = 0;
      win_base = '0;
      win_len  = '0;
      errors   = 0;
    endfunction

    function void write_reg(logic [3:0] a, logic [63:0] d);
      if (a == REG_TEXT_BASE) win_base = d[47:0];
      else if (a == REG_TEXT_LENGTH) win_len = d[31:0];
    endfunction

    function int find_addr(logic [47:0] a);
      for (int i = 0; i < n_valid; i++)
        if (bp_addr[i] == a) return i;
      return -1;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void note_command(logic [1:0] m, logic [47:0] a, logic [7:0] b,
                               logic [7:0] ix);
      bpt_pkg::res_t r;
      int            pos;
      r = '0;
      case (m)
        bpt_pkg::MODE_INSERT: begin
          if (a < win_base || 48'(a - win_base) >= {16'b0, win_len}) begin
            r.status = bpt_pkg::ST_RANGE;
          end else begin
            pos = find_addr(a);
            if (pos >= 0) begin
              r.status  = bpt_pkg::ST_DUP;
              r.index   = pos[7:0];
              r.address = bp_addr[pos];
              r.sbyte   = bp_byte[pos];
            end else if (n_valid >= bpt_pkg::TABLE_DEPTH) begin
              r.status = bpt_pkg::ST_FULL;
            end else begin
              bp_addr[n_valid] = a;
              bp_byte[n_valid] = b;
              r.status  = bpt_pkg::ST_OK;
              r.index   = n_valid[7:0];
              r.address = a;
              r.sbyte   = b;
              n_valid++;
            end
          end
        end
        bpt_pkg::MODE_DELETE: begin
          if (ix >= n_valid) begin
            r.status = bpt_pkg::ST_BADIDX;
          end else begin
            r.status  = bpt_pkg::ST_OK;
            r.index   = ix;
            r.address = bp_addr[ix];
            r.sbyte   = bp_byte[ix];
            for (int i = ix + 1; i < n_valid; i++) begin
              bp_addr[i-1] = bp_addr[i];
              bp_byte[i-1] = bp_byte[i];
            end
            n_valid--;
          end
        end
        bpt_pkg::MODE_LOOKUP: begin
          pos = find_addr(a);
          if (pos < 0) begin
            r.status = bpt_pkg::ST_NOTFOUND;
          end else begin
            r.status  = bpt_pkg::ST_OK;
            r.hit     = 1'b1;
            r.index   = pos[7:0];
            r.address = bp_addr[pos];
            r.sbyte   = bp_byte[pos];
          end
        end
        default: r.status = bpt_pkg::ST_OK;
      endcase
      r.count = n_valid[8:0];
      pending_results.push_back(r);
    endfunction

    function void check_result(bpt_pkg::res_t got);
      bpt_pkg::res_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display({"unexpected result beat: status=%0d hit=%0d index=%0d",
                    " addr=%h byte=%h count=%0d"},
                   got.status, got.hit, got.index, got.address, got.sbyte, got.count);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.hit !== want.hit ||
          got.index !== want.index || got.address !== want.address ||
          got.sbyte !== want.sbyte || got.count !== want.count) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch exp: status=%0d hit=%0d index=%0d addr=%h byte=%h count=%0d",
                   want.status, want.hit, want.index, want.address, want.sbyte,
                   want.count);
          $display("         got: status=%0d hit=%0d index=%0d addr=%h byte=%h count=%0d",
                   got.status, got.hit, got.index, got.address, got.sbyte, got.count);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;    // address[47:0], saved_byte, entry_index
  logic [1:0]  in_tuser = '0;    // mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;        // found_index, found_address, found_byte, entry_count
  logic [3:0]  out_tuser;        // status, hit
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  bp_table_mirror sb = new();
  int burst_left = 0;
  int quiet = 0;
  int rx_mode = 0;
  int rx_left = 0;
  int rx_phase = 0;

  breakpoint_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    bpt_pkg::res_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.status  = out_tuser[2:0];
        got.hit     = out_tuser[3];
        got.index   = out_tdata[7:0];
        got.address = out_tdata[55:8];
        got.sbyte   = out_tdata[63:56];
        got.count   = out_tdata[72:64];
        sb.check_result(got);
      end
      if (in_tvalid && in_tready)
        sb.note_command(in_tuser, in_tdata[47:0], in_tdata[55:48], in_tdata[63:56]);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)
        sb.write_reg(cfg_paddr, cfg_pwdata);
    end
  end

  // watchdog: cycles with no beat on any port
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready) || !rst_n) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 5) == 0);
      default: out_tready <= ((rx_phase % 7) < 3);
    endcase
    rx_phase <= rx_phase + 1;
  end

  function automatic logic [47:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[47:0];
  endfunction

  function automatic logic [47:0] pick_address();
    int          sel;
    logic [63:0] off;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      if (sb.win_len == 0) return sb.win_base;
      off = {$urandom, $urandom} % {32'b0, sb.win_len};
      return sb.win_base + off[47:0];
    end else if (sel < 70 && sb.n_valid > 0) begin
      return sb.bp_addr[$urandom_range(0, sb.n_valid - 1)];
    end else if (sel < 85) begin
      case ($urandom_range(0, 3))
        0: return sb.win_base;
        1: return sb.win_base - 48'd1;
        2: return sb.win_base + {16'b0, sb.win_len};
        default: return sb.win_base + {16'b0, sb.win_len} - 48'd1;
      endcase
    end
    return rand48();
  endfunction

  function automatic logic [7:0] pick_index();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 75 && sb.n_valid > 0) return 8'($urandom_range(0, sb.n_valid - 1));
    if (sel < 85) return 8'(sb.n_valid);
    if (sel < 90) return 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_item(input logic [1:0] m, input logic [47:0] a,
                           input logic [7:0] b, input logic [7:0] ix);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 19))
        0: gap = $urandom_range(20, 40);
        1, 2, 3, 4, 5: gap = $urandom_range(4, 12);
        default: gap = $urandom_range(0, 3);
      endcase
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= {ix, b, a};
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] a, input logic [63:0] d);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= a;
    cfg_pwdata  <= d;
    @(negedge clk);
    cfg_penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_pready) break;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_window(input logic [47:0] base, input logic [31:0] len);
    drain();
    write_reg(REG_TEXT_BASE, {16'b0, base});
    write_reg(REG_TEXT_LENGTH, {32'b0, len});
  endtask

  task automatic random_items(input int n, input int w_ins, input int w_del,
                              input int w_look);
    int         sel;
    logic [1:0] m;
    logic [7:0] ix;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < w_ins) m = bpt_pkg::MODE_INSERT;
      else if (sel < w_ins + w_del) m = bpt_pkg::MODE_DELETE;
      else if (sel < w_ins + w_del + w_look) m = bpt_pkg::MODE_LOOKUP;
      else m = MODE_UNUSED;
      ix = (m == bpt_pkg::MODE_DELETE) ? pick_index() : 8'($urandom_range(0, 255));
      if ($urandom_range(0, 199) == 0) drain();
      send_item(m, pick_address(), 8'($urandom_range(0, 255)), ix);
    end
  endtask

  task automatic fill_table();
    int         guard;
    logic [1:0] m;
    guard = 0;
    while (sb.n_valid < bpt_pkg::TABLE_DEPTH && guard < 600) begin
      m = ($urandom_range(0, 9) == 0) ? bpt_pkg::MODE_LOOKUP : bpt_pkg::MODE_INSERT;
      send_item(m, sb.win_base + {16'b0, 32'($urandom)}, 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
      guard++;
    end
  endtask

  initial begin
    logic [47:0] base;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table, zero-length window
    send_item(bpt_pkg::MODE_INSERT, 48'h0, 8'h11, 8'h00);
    send_item(bpt_pkg::MODE_DELETE, 48'h0, 8'h00, 8'h00);
    send_item(bpt_pkg::MODE_LOOKUP, 48'h0, 8'h00, 8'h00);
    send_item(MODE_UNUSED, rand48(), 8'($urandom), 8'($urandom));

    base = 48'h0000_0040_0000;
    set_window(base, 32'h100);
    send_item(bpt_pkg::MODE_INSERT, base, 8'h00, 8'hff);
    send_item(bpt_pkg::MODE_INSERT, base + 48'hff, 8'hff, 8'h00);
    send_item(bpt_pkg::MODE_INSERT, base + 48'h100, 8'h33, 8'h00);
    send_item(bpt_pkg::MODE_INSERT, base - 48'h1, 8'h44, 8'h00);
    send_item(bpt_pkg::MODE_INSERT, base, 8'h5a, 8'h00);
    send_item(bpt_pkg::MODE_LOOKUP, base + 48'hff, 8'h00, 8'h00);
    send_item(bpt_pkg::MODE_LOOKUP, base + 48'h1, 8'h00, 8'h00);
    send_item(bpt_pkg::MODE_DELETE, 48'h0, 8'h00, 8'hff);
    send_item(bpt_pkg::MODE_DELETE, 48'h0, 8'h00, 8'h02);
    send_item(bpt_pkg::MODE_INSERT, base + 48'h7, 8'ha5, 8'h00);
    send_item(bpt_pkg::MODE_DELETE, 48'hffff_ffff_ffff, 8'hff, 8'h00);
    send_item(bpt_pkg::MODE_LOOKUP, base + 48'h7, 8'h00, 8'h00);
    send_item(MODE_UNUSED, 48'hffff_ffff_ffff, 8'hff, 8'hff);

    set_window(48'hffff_ffff_ffff, 32'hffff_ffff);
    send_item(bpt_pkg::MODE_INSERT, 48'hffff_ffff_ffff, 8'hc3, 8'h00);
    send_item(bpt_pkg::MODE_INSERT, 48'hffff_ffff_fffe, 8'h3c, 8'h00);
    send_item(bpt_pkg::MODE_LOOKUP, 48'hffff_ffff_ffff, 8'h00, 8'h00);
    send_item(bpt_pkg::MODE_DELETE, 48'h0, 8'h00, 8'h02);

    // small window: duplicates and hits are common
    set_window(rand48(), 32'd64);
    random_items(300, 40, 25, 30);

    // fill to capacity, then work around the full table
    set_window({16'($urandom), 32'h0}, 32'hffff_ffff);
    fill_table();
    random_items(200, 50, 15, 30);

    // tiny window, mostly shrinking
    set_window(48'h0, 32'($urandom_range(1, 16)));
    random_items(200, 30, 40, 25);

    // window at the top of the address space
    set_window(48'hffff_ffff_ffff - 48'd100, 32'hffff_ffff);
    random_items(250, 40, 25, 30);

    set_window(rand48(), 32'h0);
    random_items(80, 30, 30, 35);

    set_window(rand48(), 32'($urandom));
    random_items(240, 40, 25, 30);

    drain();
    repeat (END_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      $display("%0d results never arrived", sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
